/* src/i2c_register_transfer_sequencer_assert.svh */
// Assertion macros used by the I2C register transfer sequencer control module.
`ifndef I2C_REGISTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_REGISTER_TRANSFER_SEQUENCER_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define RTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define RTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/i2c_rts_pkg.sv */
// Package: types and constants of the I2C register transfer sequencer.
`default_nettype none

package i2c_rts_pkg;

  localparam int WRITE_DEPTH_DEF = 256;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_START_WR = 3'd1,
    CMD_START_RD = 3'd2,
    CMD_TX_READY = 3'd3,
    CMD_RX_BYTE  = 3'd4,
    CMD_NACK     = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [6:0] slave_addr;
    logic [7:0] reg_addr;
    logic [7:0] xfer_length;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [6:0] target_addr;
    logic       start_tx;
    logic       restart_rx;
    logic       stop_req;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [7:0] rx_position;
    logic       done_res;
    logic       success;
  } result_t;

  // Control from the sequencer to the write store.
  typedef struct packed {
    logic load;       // write data_byte at the load pointer
    logic load_wrap;  // load count wraps to zero with this load
    logic clear;      // start command: both pointers back to entry 0
    logic rd_en;      // read at the send pointer and step it
  } store_ctl_t;

endpackage

`default_nettype wire

/* src/i2c_rts_store.sv */
// Write data store: load and send pointers with registered read data.
`default_nettype none

module i2c_rts_store #(
  parameter int WRITE_DEPTH = i2c_rts_pkg::WRITE_DEPTH_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire i2c_rts_pkg::store_ctl_t ctl,
  input  wire logic [7:0]              wr_data,
  output logic [7:0]                   rd_data
);

  localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(WRITE_DEPTH - 1);

  logic [7:0]    mem [WRITE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (ctl.clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (ctl.load) begin
        wr_ptr <= (ctl.load_wrap || wr_ptr == LAST_ADDR) ? '0 : wr_ptr + AW'(1);
      end
      if (ctl.rd_en) begin
        rd_ptr <= (rd_ptr == LAST_ADDR) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mem[wr_ptr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_ptr];
    end
  end

endmodule

`default_nettype wire

/* src/i2c_rts_ctrl.sv */
// Sequencer: decodes one word per cycle unless stalled into state and result.
`default_nettype none

module i2c_rts_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    item_vld,
  input  wire i2c_rts_pkg::item_t      item,
  input  wire logic                    out_stall,
  output logic                         advance,
  output logic                         res_vld,
  output i2c_rts_pkg::result_t         res,
  output logic                         res_from_store,
  output i2c_rts_pkg::store_ctl_t      st_ctl
);

  logic go;

  logic       busy, busy_next;
  logic       write_mode, write_mode_next;
  logic [7:0] saved_reg, saved_reg_next;
  logic       reg_sent, reg_sent_next;
  logic [7:0] byte_index, byte_index_next;
  logic [7:0] byte_total, byte_total_next;
  logic [7:0] load_count, load_count_next;
  logic       rx_phase, rx_phase_next;

  i2c_rts_pkg::result_t r;
  logic                 from_st;
  logic [7:0]           idx_t;

  assign advance = !res_vld || !out_stall;
  assign go      = item_vld && advance;

  always_comb begin
    busy_next       = busy;
    write_mode_next = write_mode;
    saved_reg_next  = saved_reg;
    reg_sent_next   = reg_sent;
    byte_index_next = byte_index;
    byte_total_next = byte_total;
    load_count_next = load_count;
    rx_phase_next   = rx_phase;
    r               = '0;
    from_st         = 1'b0;
    st_ctl          = '0;
    idx_t           = byte_index;
    if (go) begin
      unique case (item.cmd)
        i2c_rts_pkg::CMD_LOAD: begin
          st_ctl.load      = 1'b1;
          st_ctl.load_wrap = (load_count == 8'hFF);
          load_count_next  = load_count + 8'd1;
        end
        i2c_rts_pkg::CMD_START_WR, i2c_rts_pkg::CMD_START_RD: begin
          busy_next       = 1'b1;
          write_mode_next = (item.cmd == i2c_rts_pkg::CMD_START_WR);
          saved_reg_next  = item.reg_addr;
          reg_sent_next   = 1'b0;
          byte_index_next = 8'd0;
          byte_total_next = item.xfer_length;
          load_count_next = 8'd0;
          rx_phase_next   = 1'b0;
          st_ctl.clear    = 1'b1;
          r.target_addr   = item.slave_addr;
          r.start_tx      = 1'b1;
        end
        i2c_rts_pkg::CMD_TX_READY: begin
          if (busy) begin
            if (!reg_sent) begin
              r.tx_valid    = 1'b1;
              r.tx_byte     = saved_reg;
              reg_sent_next = 1'b1;
            end else if (write_mode) begin
              if (byte_index == byte_total) begin
                r.stop_req    = 1'b1;
                r.done_res    = 1'b1;
                r.success     = 1'b1;
                busy_next     = 1'b0;
                rx_phase_next = 1'b0;
              end else begin
                r.tx_valid      = 1'b1;
                from_st         = 1'b1;
                st_ctl.rd_en    = 1'b1;
                byte_index_next = byte_index + 8'd1;
              end
            end else if (!rx_phase) begin
              r.restart_rx  = 1'b1;
              rx_phase_next = 1'b1;
              r.stop_req    = (byte_total == 8'd1);
            end
          end
        end
        i2c_rts_pkg::CMD_RX_BYTE: begin
          if (busy && !write_mode && rx_phase) begin
            if (byte_index < byte_total) begin
              r.rx_valid    = 1'b1;
              r.rx_byte     = item.data_byte;
              r.rx_position = byte_index;
              idx_t         = byte_index + 8'd1;
            end
            byte_index_next = idx_t;
            if ({1'b0, idx_t} + 9'd1 == {1'b0, byte_total}) begin
              r.stop_req = 1'b1;
            end
            if (idx_t == byte_total) begin
              r.done_res    = 1'b1;
              r.success     = 1'b1;
              busy_next     = 1'b0;
              rx_phase_next = 1'b0;
            end
          end
        end
        i2c_rts_pkg::CMD_NACK: begin
          if (busy) begin
            r.done_res    = 1'b1;
            busy_next     = 1'b0;
            rx_phase_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      write_mode <= 1'b0;
      saved_reg  <= 8'd0;
      reg_sent   <= 1'b0;
      byte_index <= 8'd0;
      byte_total <= 8'd0;
      load_count <= 8'd0;
      rx_phase   <= 1'b0;
      res_vld    <= 1'b0;
    end else begin
      busy       <= busy_next;
      write_mode <= write_mode_next;
      saved_reg  <= saved_reg_next;
      reg_sent   <= reg_sent_next;
      byte_index <= byte_index_next;
      byte_total <= byte_total_next;
      load_count <= load_count_next;
      rx_phase   <= rx_phase_next;
      if (advance) begin
        res_vld <= item_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res            <= r;
      res_from_store <= from_st;
    end
  end

  `include "i2c_register_transfer_sequencer_assert.svh"

  `RTS_ASSERT_NEXT(a_done_clears_busy, go && r.done_res, !busy)
  `RTS_ASSERT_NOW(a_rx_phase_in_read, rx_phase, busy && !write_mode)
  `RTS_ASSERT_NOW(a_index_in_range, busy, byte_index <= byte_total)
  `RTS_ASSERT_NOW(a_store_only_for_tx, res_vld && res_from_store, res.tx_valid && !res.done_res)

endmodule

`default_nettype wire

/* src/i2c_register_transfer_sequencer.sv */
// Top level of the I2C register transfer sequencer: input register and wiring.
//
// One word enters per cycle while in_stall is low, and each word gives exactly
// one result word. The accepting edge loads the input register, and the result
// register is then loaded from it once it is empty or not stalled. The write
// store is read at the edge that captures the result, so a store byte shows up
// on tx_byte together with the rest of its result. Input stall rises only while
// a word sits in the input register and the result register is full and
// stalled; the store has no clearing pass after reset.
`default_nettype none

module i2c_register_transfer_sequencer #(
  parameter int WRITE_DEPTH = i2c_rts_pkg::WRITE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire i2c_rts_pkg::item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output i2c_rts_pkg::result_t      out_data
);

  logic                    item_vld;
  i2c_rts_pkg::item_t      item;
  logic                    advance;
  i2c_rts_pkg::result_t    res;
  logic                    res_from_store;
  i2c_rts_pkg::store_ctl_t st_ctl;
  logic [7:0]              rd_data;

  assign in_stall = item_vld && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else if (!in_stall) begin
      item_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  i2c_rts_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .item_vld       (item_vld),
    .item           (item),
    .out_stall      (out_stall),
    .advance        (advance),
    .res_vld        (out_valid),
    .res            (res),
    .res_from_store (res_from_store),
    .st_ctl         (st_ctl)
  );

  i2c_rts_store #(
    .WRITE_DEPTH (WRITE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctl     (st_ctl),
    .wr_data (item.data_byte),
    .rd_data (rd_data)
  );

  always_comb begin
    out_data = res;
    if (res_from_store) begin
      out_data.tx_byte = rd_data;
    end
  end

endmodule

`default_nettype wire

/* bench/i2c_register_transfer_sequencer_tb.sv */
// Self-checking testbench for the I2C register transfer sequencer.
`timescale 1ns / 1ps

module i2c_register_transfer_sequencer_tb;

  localparam i2c_rts_pkg::cmd_t CMD_RSVD6 = i2c_rts_pkg::cmd_t'(3'd6);
  localparam i2c_rts_pkg::cmd_t CMD_RSVD7 = i2c_rts_pkg::cmd_t'(3'd7);
  localparam int RANDOM_WORDS = 1350;
  localparam int CALM_WORDS = 150;

  typedef enum {
    EXP_MODEL, EXP_NONE, EXP_START, EXP_TX, EXP_STOP_OK, EXP_RESTART_STOP,
    EXP_RX_LAST, EXP_NACK
  } row_exp_t;

  typedef struct {
    i2c_rts_pkg::item_t w;
    row_exp_t           kind;
    logic [7:0]         val;
  } row_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  i2c_rts_pkg::item_t   in_data;
  logic                 out_valid;
  logic                 out_stall;
  i2c_rts_pkg::result_t out_data;

  // transfer state as the sequencer should hold it
  logic       xfer_busy;
  logic       xfer_write;
  logic       reg_done;
  logic       rx_phase;
  logic [7:0] xfer_reg;
  logic [7:0] xfer_idx;
  logic [7:0] xfer_len;
  logic [7:0] load_ptr;
  logic [7:0] wr_bytes [256];
  bit         wr_loaded [256];

  i2c_rts_pkg::result_t pending_results [$];
  i2c_rts_pkg::result_t want;
  row_t                 rows [$];
  int                   errors;
  int                   counted;
  int                   big_left;
  int                   in_idle_pct;
  int                   out_idle_pct;
  bit                   calm;

  i2c_register_transfer_sequencer DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic i2c_rts_pkg::result_t transfer_step(i2c_rts_pkg::item_t w);
    i2c_rts_pkg::result_t r;
    r = '0;
    case (w.cmd)
      i2c_rts_pkg::CMD_LOAD: begin
        wr_bytes[load_ptr] = w.data_byte;
        wr_loaded[load_ptr] = 1'b1;
        load_ptr = load_ptr + 8'd1;
      end
      i2c_rts_pkg::CMD_START_WR, i2c_rts_pkg::CMD_START_RD: begin
        xfer_busy = 1'b1;
        xfer_write = (w.cmd == i2c_rts_pkg::CMD_START_WR);
        xfer_reg = w.reg_addr;
        reg_done = 1'b0;
        xfer_idx = '0;
        xfer_len = w.xfer_length;
        load_ptr = '0;
        rx_phase = 1'b0;
        r.target_addr = w.slave_addr;
        r.start_tx = 1'b1;
      end
      i2c_rts_pkg::CMD_TX_READY: begin
        if (xfer_busy) begin
          if (!reg_done) begin
            r.tx_valid = 1'b1;
            r.tx_byte = xfer_reg;
            reg_done = 1'b1;
          end else if (xfer_write) begin
            if (xfer_idx == xfer_len) begin
              r.stop_req = 1'b1;
              r.done_res = 1'b1;
              r.success = 1'b1;
              xfer_busy = 1'b0;
              rx_phase = 1'b0;
            end else begin
              r.tx_valid = 1'b1;
              r.tx_byte = wr_bytes[xfer_idx];
              xfer_idx = xfer_idx + 8'd1;
            end
          end else if (!rx_phase) begin
            r.restart_rx = 1'b1;
            rx_phase = 1'b1;
            r.stop_req = (xfer_len == 8'd1);
          end
        end
      end
      i2c_rts_pkg::CMD_RX_BYTE: begin
        if (xfer_busy && !xfer_write && rx_phase) begin
          if (xfer_idx < xfer_len) begin
            r.rx_valid = 1'b1;
            r.rx_byte = w.data_byte;
            r.rx_position = xfer_idx;
            xfer_idx = xfer_idx + 8'd1;
          end
          if ({1'b0, xfer_idx} + 9'd1 == {1'b0, xfer_len}) r.stop_req = 1'b1;
          if (xfer_idx == xfer_len) begin
            r.done_res = 1'b1;
            r.success = 1'b1;
            xfer_busy = 1'b0;
            rx_phase = 1'b0;
          end
        end
      end
      i2c_rts_pkg::CMD_NACK: begin
        if (xfer_busy) begin
          r.done_res = 1'b1;
          xfer_busy = 1'b0;
          rx_phase = 1'b0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic i2c_rts_pkg::item_t word_of(i2c_rts_pkg::cmd_t c);
    i2c_rts_pkg::item_t w;
    w.cmd = c;
    w.slave_addr = 7'($urandom);
    w.reg_addr = 8'($urandom);
    w.xfer_length = 8'($urandom);
    w.data_byte = 8'($urandom);
    return w;
  endfunction

  // mostly short transfers, a couple near the full length
  function automatic logic [7:0] pick_len();
    if (big_left > 0 && $urandom_range(0, 39) == 0) begin
      big_left--;
      return 8'($urandom_range(250, 255));
    end
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(7, 40));
    return 8'($urandom_range(0, 6));
  endfunction

  task automatic report_mismatch(string what, int got, int exp_val);
    errors++;
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, exp_val, $time);
  endtask

  task automatic add_row(i2c_rts_pkg::cmd_t c, int a, int g, int l, int d, row_exp_t k,
                         int v);
    row_t rw;
    rw.w.cmd = c;
    rw.w.slave_addr = 7'(a);
    rw.w.reg_addr = 8'(g);
    rw.w.xfer_length = 8'(l);
    rw.w.data_byte = 8'(d);
    rw.kind = k;
    rw.val = 8'(v);
    rows.push_back(rw);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input i2c_rts_pkg::item_t w, input bit typed,
                           input i2c_rts_pkg::result_t typed_res, output bit active);
    i2c_rts_pkg::result_t r;
    // never let a write send a store entry that was not loaded
    if (w.cmd == i2c_rts_pkg::CMD_TX_READY && xfer_busy && reg_done && xfer_write &&
        xfer_idx != xfer_len && !wr_loaded[xfer_idx])
      w.cmd = i2c_rts_pkg::CMD_NACK;
    if (!calm && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = transfer_step(w);
    pending_results.push_back(typed ? typed_res : r);
    active = (r != '0) || (w.cmd == i2c_rts_pkg::CMD_LOAD);
    @(negedge clk);
  endtask

  task automatic feed(input i2c_rts_pkg::item_t w);
    bit act;
    if ($urandom_range(0, 99) < 3) begin
      send_word(word_of(i2c_rts_pkg::cmd_t'(3'($urandom))), 1'b0, '0, act);
      counted += act;
    end
    send_word(w, 1'b0, '0, act);
    counted += act;
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 99) < out_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.target_addr !== want.target_addr)
          report_mismatch("target_addr", out_data.target_addr, want.target_addr);
        if (out_data.start_tx !== want.start_tx)
          report_mismatch("start_tx", out_data.start_tx, want.start_tx);
        if (out_data.restart_rx !== want.restart_rx)
          report_mismatch("restart_rx", out_data.restart_rx, want.restart_rx);
        if (out_data.stop_req !== want.stop_req)
          report_mismatch("stop_req", out_data.stop_req, want.stop_req);
        if (out_data.tx_valid !== want.tx_valid)
          report_mismatch("tx_valid", out_data.tx_valid, want.tx_valid);
        if (out_data.tx_byte !== want.tx_byte)
          report_mismatch("tx_byte", out_data.tx_byte, want.tx_byte);
        if (out_data.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", out_data.rx_valid, want.rx_valid);
        if (out_data.rx_byte !== want.rx_byte)
          report_mismatch("rx_byte", out_data.rx_byte, want.rx_byte);
        if (out_data.rx_position !== want.rx_position)
          report_mismatch("rx_position", out_data.rx_position, want.rx_position);
        if (out_data.done_res !== want.done_res)
          report_mismatch("done_res", out_data.done_res, want.done_res);
        if (out_data.success !== want.success)
          report_mismatch("success", out_data.success, want.success);
      end
    end
  end

  initial begin
    i2c_rts_pkg::result_t r;
    bit                   act;
    i2c_rts_pkg::item_t   w;
    int                   i;
    int                   n;
    int                   steps;
    int                   abort_at;
    int                   pick;

    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    xfer_busy = 1'b0;
    xfer_write = 1'b0;
    reg_done = 1'b0;
    rx_phase = 1'b0;
    xfer_reg = '0;
    xfer_idx = '0;
    xfer_len = '0;
    load_ptr = '0;
    foreach (wr_loaded[j]) wr_loaded[j] = 1'b0;
    errors = 0;
    counted = 0;
    big_left = 2;
    in_idle_pct = 20;
    out_idle_pct = 20;
    calm = 1'b0;

    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_RX_BYTE, 127, 255, 255, 255, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_NACK, 0, 0, 0, 0, EXP_NONE, 0);
    add_row(CMD_RSVD6, 127, 255, 255, 255, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_LOAD, 0, 0, 0, 255, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_LOAD, 0, 0, 0, 0, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_START_WR, 127, 255, 2, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_TX, 255);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_STOP_OK, 0);
    add_row(i2c_rts_pkg::CMD_START_WR, 0, 0, 0, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_TX, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_STOP_OK, 0);
    add_row(i2c_rts_pkg::CMD_START_RD, 85, 128, 1, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_RX_BYTE, 0, 0, 0, 17, EXP_NONE, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_TX, 128);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_RESTART_STOP, 0);
    add_row(i2c_rts_pkg::CMD_RX_BYTE, 0, 0, 0, 90, EXP_RX_LAST, 90);
    add_row(i2c_rts_pkg::CMD_START_RD, 1, 1, 0, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_RX_BYTE, 0, 0, 0, 255, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_START_RD, 42, 16, 255, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_TX_READY, 0, 0, 0, 0, EXP_MODEL, 0);
    add_row(i2c_rts_pkg::CMD_START_WR, 51, 68, 0, 0, EXP_START, 0);
    add_row(i2c_rts_pkg::CMD_NACK, 0, 0, 0, 0, EXP_NACK, 0);
    add_row(CMD_RSVD7, 0, 0, 0, 0, EXP_NONE, 0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[k]) begin
      r = '0;
      case (rows[k].kind)
        EXP_START: begin
          r.target_addr = rows[k].w.slave_addr;
          r.start_tx = 1'b1;
        end
        EXP_TX: begin
          r.tx_valid = 1'b1;
          r.tx_byte = rows[k].val;
        end
        EXP_STOP_OK: begin
          r.stop_req = 1'b1;
          r.done_res = 1'b1;
          r.success = 1'b1;
        end
        EXP_RESTART_STOP: begin
          r.restart_rx = 1'b1;
          r.stop_req = 1'b1;
        end
        EXP_RX_LAST: begin
          r.rx_valid = 1'b1;
          r.rx_byte = rows[k].val;
          r.done_res = 1'b1;
          r.success = 1'b1;
        end
        EXP_NACK: r.done_res = 1'b1;
        default: ;
      endcase
      send_word(rows[k].w, rows[k].kind != EXP_MODEL, r, act);
    end

    while (counted < RANDOM_WORDS) begin
      calm = (counted >= RANDOM_WORDS - CALM_WORDS);
      in_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      out_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
      pick = $urandom_range(0, 99);
      n = pick_len();
      if (pick < 45) begin
        for (i = 0; i < n; i++) feed(word_of(i2c_rts_pkg::CMD_LOAD));
        w = word_of(i2c_rts_pkg::CMD_START_WR);
        w.xfer_length = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, n)) : 8'(n);
        feed(w);
        steps = w.xfer_length + 2;
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps - 1) : steps;
        for (i = 0; i < steps; i++) begin
          if (i == abort_at) begin
            feed(word_of(i2c_rts_pkg::CMD_NACK));
            break;
          end
          feed(word_of(i2c_rts_pkg::CMD_TX_READY));
        end
      end else if (pick < 85) begin
        w = word_of(i2c_rts_pkg::CMD_START_RD);
        w.xfer_length = 8'(n);
        feed(w);
        steps = 2 + ((n == 0) ? 1 : n);
        abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, steps - 1) : steps;
        for (i = 0; i < steps; i++) begin
          if (i == abort_at) begin
            feed(word_of(i2c_rts_pkg::CMD_NACK));
            break;
          end
          feed(word_of((i < 2) ? i2c_rts_pkg::CMD_TX_READY : i2c_rts_pkg::CMD_RX_BYTE));
        end
      end else begin
        repeat ($urandom_range(1, 4)) feed(word_of(i2c_rts_pkg::cmd_t'(3'($urandom))));
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/i2c_rts_pkg.sv
src/i2c_rts_store.sv
src/i2c_rts_ctrl.sv
src/i2c_register_transfer_sequencer.sv
bench/i2c_register_transfer_sequencer_tb.sv
